FILE: design/bmt_pkg.sv
// Shared types and constants for the breakpoint match table.
package bmt_pkg;

   localparam int ADDR_W = 64;
   localparam int BYTE_W = 8;
   localparam int ID_W   = 8;
   localparam int SLOT_W = 4;
   localparam int OP_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_HIT    = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_FIND   = 2'd3
   } opcode_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture request fields, clear scan index
      logic inc_idx;    // step scan index
      logic set_idx_id; // scan index takes the request id
      logic ram_rd;     // read table entry at scan index
      logic ins_write;  // write request into entry at scan index, mark valid
      logic res_ram;    // result from entry just read, slot = scan index
      logic res_fail;   // failure result
      logic del_clear;  // clear valid bit at scan index
      logic push;       // move result into output register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      opcode_type op;
      logic       id_ok;     // id in range and entry valid
      logic       idx_last;  // scan index at last entry
      logic       idx_valid; // entry at scan index valid
      logic       hit;       // entry just read is valid and matches probe
      logic       out_free;  // output register can take a result
   } ctl_status_type;

endpackage

FILE: design/bmt_req_if.sv
// Request channel: opcode, address, original byte and id with valid/ready.
interface bmt_req_if;
   logic                      valid;
   logic                      ready;
   logic [bmt_pkg::OP_W-1:0]   opcode;
   logic [bmt_pkg::ADDR_W-1:0] address;
   logic [bmt_pkg::BYTE_W-1:0] original_byte;
   logic [bmt_pkg::ID_W-1:0]   slot_id;

   modport source (output valid, opcode, address, original_byte, slot_id, input ready);
   modport sink (input valid, opcode, address, original_byte, slot_id, output ready);
endinterface

FILE: design/bmt_rsp_if.sv
// Response channel: ok, slot, stored byte and stored address with valid/ready.
interface bmt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       ok;
   logic [bmt_pkg::SLOT_W-1:0] slot;
   logic [bmt_pkg::BYTE_W-1:0] stored_byte;
   logic [bmt_pkg::ADDR_W-1:0] stored_address;

   modport source (output valid, ok, slot, stored_byte, stored_address, input ready);
   modport sink (input valid, ok, slot, stored_byte, stored_address, output ready);
endinterface

FILE: design/bmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/bmt_dp.sv
// Datapath: request registers, valid bits, entry RAM, comparator, result registers.
module bmt_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bmt_pkg::ADDR_W-1:0]          csr_wr_data,
   input  logic [bmt_pkg::OP_W-1:0]            req_opcode,
   input  logic [bmt_pkg::ADDR_W-1:0]          req_address,
   input  logic [bmt_pkg::BYTE_W-1:0]          req_original_byte,
   input  logic [bmt_pkg::ID_W-1:0]            req_slot_id,
   input  bmt_pkg::ctl_cmd_type                cmd,
   output bmt_pkg::ctl_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [bmt_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [bmt_pkg::BYTE_W-1:0]          rsp_stored_byte,
   output logic [bmt_pkg::ADDR_W-1:0]          rsp_stored_address
);
   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENTRY_W = bmt_pkg::ADDR_W + bmt_pkg::BYTE_W;

   // configuration
   logic [bmt_pkg::ADDR_W-1:0] base_ff, base_in;

   // captured request
   bmt_pkg::opcode_type        op_ff;
   logic [bmt_pkg::ADDR_W-1:0] addr_ff;
   logic [bmt_pkg::BYTE_W-1:0] byte_ff;
   logic [bmt_pkg::ID_W-1:0]   id_ff;

   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // result staging and output register
   logic                       res_ok_ff;
   logic [bmt_pkg::SLOT_W-1:0] res_slot_ff;
   logic [bmt_pkg::BYTE_W-1:0] res_byte_ff;
   logic [bmt_pkg::ADDR_W-1:0] res_addr_ff;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_ok_ff;
   logic [bmt_pkg::SLOT_W-1:0] out_slot_ff;
   logic [bmt_pkg::BYTE_W-1:0] out_byte_ff;
   logic [bmt_pkg::ADDR_W-1:0] out_addr_ff;

   logic [ENTRY_W-1:0]         ram_rd_data;
   logic [ENTRY_W-1:0]         ram_wr_data;
   logic [bmt_pkg::ADDR_W-1:0] ent_addr;
   logic [bmt_pkg::BYTE_W-1:0] ent_byte;
   logic [bmt_pkg::ADDR_W-1:0] ent_sum;
   logic [IDX_W+bmt_pkg::SLOT_W-1:0] idx_ext;
   logic [bmt_pkg::SLOT_W-1:0] idx_slot;
   logic                       id_in_range;
   logic [IDX_W-1:0]           id_idx;

   assign ram_wr_data = {addr_ff, byte_ff};
   assign ent_addr    = ram_rd_data[ENTRY_W-1 -: bmt_pkg::ADDR_W];
   assign ent_byte    = ram_rd_data[bmt_pkg::BYTE_W-1:0];
   assign ent_sum     = ent_addr + base_ff;
   assign idx_ext     = {{bmt_pkg::SLOT_W{1'b0}}, idx_ff};
   assign idx_slot    = idx_ext[bmt_pkg::SLOT_W-1:0];
   assign id_in_range = {1'b0, id_ff} < (bmt_pkg::ID_W+1)'(TABLE_ENTRIES);
   assign id_idx      = id_ff[IDX_W-1:0];

   bmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_write),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      base_in = csr_wr_en ? csr_wr_data : base_ff;

      idx_in = idx_ff;
      if (cmd.load_req) begin
         idx_in = '0;
      end else if (cmd.set_idx_id) begin
         idx_in = id_idx;
      end else if (cmd.inc_idx) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      valid_in = valid_ff;
      if (cmd.ins_write) begin
         valid_in[idx_ff] = 1'b1;
      end
      if (cmd.del_clear) begin
         valid_in[idx_ff] = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (cmd.push) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         idx_ff       <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= bmt_pkg::opcode_type'(req_opcode);
         addr_ff <= req_address;
         byte_ff <= req_original_byte;
         id_ff   <= req_slot_id;
      end
      if (cmd.res_fail) begin
         res_ok_ff   <= 1'b0;
         res_slot_ff <= '0;
         res_byte_ff <= '0;
         res_addr_ff <= '0;
      end else if (cmd.res_ram) begin
         res_ok_ff   <= 1'b1;
         res_slot_ff <= idx_slot;
         res_byte_ff <= ent_byte;
         res_addr_ff <= ent_addr;
      end else if (cmd.ins_write) begin
         res_ok_ff   <= 1'b1;
         res_slot_ff <= idx_slot;
         res_byte_ff <= byte_ff;
         res_addr_ff <= addr_ff;
      end
      if (cmd.push) begin
         out_ok_ff   <= res_ok_ff;
         out_slot_ff <= res_slot_ff;
         out_byte_ff <= res_byte_ff;
         out_addr_ff <= res_addr_ff;
      end
   end

   assign status.op        = op_ff;
   assign status.id_ok     = id_in_range && valid_ff[id_idx];
   assign status.idx_last  = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign status.idx_valid = valid_ff[idx_ff];
   assign status.hit       = valid_ff[idx_ff] && (ent_sum == addr_ff);
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid          = out_valid_ff;
   assign rsp_ok             = out_ok_ff;
   assign rsp_slot           = out_slot_ff;
   assign rsp_stored_byte    = out_byte_ff;
   assign rsp_stored_address = out_addr_ff;
endmodule

FILE: design/bmt_ctl.sv
// Controller: sequences one transaction at a time over the datapath.
module bmt_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output bmt_pkg::ctl_cmd_type    cmd,
   input  bmt_pkg::ctl_status_type status
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_HIT_RD,
      S_HIT_CMP,
      S_INS,
      S_ID_RD,
      S_ID_DATA,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op)
               bmt_pkg::OP_HIT:    state_in = S_HIT_RD;
               bmt_pkg::OP_INSERT: state_in = S_INS;
               default: begin
                  if (status.id_ok) begin
                     cmd.set_idx_id = 1'b1;
                     state_in       = S_ID_RD;
                  end else begin
                     cmd.res_fail = 1'b1;
                     state_in     = S_RESP;
                  end
               end
            endcase
         end
         S_HIT_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_HIT_CMP;
         end
         S_HIT_CMP: begin
            if (status.hit) begin
               cmd.res_ram = 1'b1;
               state_in    = S_RESP;
            end else if (status.idx_last) begin
               cmd.res_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_HIT_RD;
            end
         end
         S_INS: begin
            if (!status.idx_valid) begin
               cmd.ins_write = 1'b1;
               state_in      = S_RESP;
            end else if (status.idx_last) begin
               cmd.res_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         S_ID_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_ID_DATA;
         end
         S_ID_DATA: begin
            cmd.res_ram   = 1'b1;
            cmd.del_clear = (status.op == bmt_pkg::OP_DELETE);
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: design/breakpoint_match_table.sv
// Top level of the breakpoint match table.
//
// A table of TABLE_ENTRIES breakpoint slots (1..256), each a valid bit plus a
// stored 64-bit address and saved original byte. Request opcodes: hit check
// (0) compares stored address + base_offset (wrapping mod 2^64) with the probe
// and reports the lowest matching slot; insert (1) fills the lowest free slot;
// delete (2) clears a valid slot by id; find (3) reports whether an id is
// valid. Every transaction returns exactly one response; on failure ok, slot,
// stored_byte and stored_address are all 0. Delete reports the contents the
// slot held before it was cleared. The slot field carries the low 4 bits of
// the slot index. One transaction is in flight at a time. Addresses and bytes
// live in a single-port-read RAM and the table is scanned one slot per step:
// a hit check does one RAM read plus one add-and-compare per slot, up to
// TABLE_ENTRIES slots; an insert checks one valid bit per cycle; delete and
// find read only the slot named by the id, none if it is out of range or not
// valid. The response waits in an output register, so a new request is accepted
// while the previous response is still pending on rsp_if. base_offset is
// written through csr_wr_en/csr_wr_data; the user must do so only while the
// block is idle, which the block itself does not enforce; it resets to 0. Reset
// is synchronous and active high; all slots come out of reset free.
module breakpoint_match_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bmt_pkg::ADDR_W-1:0]  csr_wr_data,
   bmt_req_if.sink                     req_if,
   bmt_rsp_if.source                   rsp_if
);
   bmt_pkg::ctl_cmd_type    cmd;
   bmt_pkg::ctl_status_type status;

   // sequencing: accept, dispatch, scan, respond
   bmt_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // table storage, comparator and response registers
   bmt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_opcode         (req_if.opcode),
      .req_address        (req_if.address),
      .req_original_byte  (req_if.original_byte),
      .req_slot_id        (req_if.slot_id),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_ok             (rsp_if.ok),
      .rsp_slot           (rsp_if.slot),
      .rsp_stored_byte    (rsp_if.stored_byte),
      .rsp_stored_address (rsp_if.stored_address)
   );
endmodule

FILE: bench/bmt_table_checker.sv
// Checker for the breakpoint match table: watches both channels, predicts, compares.
`timescale 1ns / 1ps

module bmt_table_checker #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   bmt_req_if                         req_mon,
   bmt_rsp_if                         rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [bmt_pkg::ADDR_W-1:0] csr_wr_data,
   output int                         errors,
   output int                         outstanding
);

   typedef struct packed {
      logic                       ok;
      logic [bmt_pkg::SLOT_W-1:0] slot;
      logic [bmt_pkg::BYTE_W-1:0] stored_byte;
      logic [bmt_pkg::ADDR_W-1:0] stored_address;
   } bp_result_type;

   // mirror of the table and of the base register
   logic                       slot_live  [TABLE_ENTRIES];
   logic [bmt_pkg::ADDR_W-1:0] slot_addr  [TABLE_ENTRIES];
   logic [bmt_pkg::BYTE_W-1:0] slot_saved [TABLE_ENTRIES];
   logic [bmt_pkg::ADDR_W-1:0] load_base;

   bp_result_type pending_rsp[$];

   task automatic report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endtask

   function automatic bp_result_type slot_result(int idx);
      bp_result_type r;
      r.ok             = 1'b1;
      r.slot           = idx[bmt_pkg::SLOT_W-1:0];
      r.stored_byte    = slot_saved[idx];
      r.stored_address = slot_addr[idx];
      return r;
   endfunction

   // apply one request to the mirror and return the response it should give
   function automatic bp_result_type apply_request(bmt_pkg::opcode_type op,
                                                   logic [bmt_pkg::ADDR_W-1:0] addr,
                                                   logic [bmt_pkg::BYTE_W-1:0] orig,
                                                   logic [bmt_pkg::ID_W-1:0] id);
      bp_result_type              r;
      logic [bmt_pkg::ADDR_W-1:0] rebased;
      r = '0;
      case (op)
         bmt_pkg::OP_HIT: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               rebased = slot_addr[i] + load_base;
               if (slot_live[i] && rebased == addr) begin
                  r = slot_result(i);
                  break;
               end
            end
         end
         bmt_pkg::OP_INSERT: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!slot_live[i]) begin
                  slot_live[i]  = 1'b1;
                  slot_addr[i]  = addr;
                  slot_saved[i] = orig;
                  r = slot_result(i);
                  break;
               end
            end
         end
         default: begin
            if (int'(id) < TABLE_ENTRIES && slot_live[id]) begin
               r = slot_result(int'(id));
               if (op == bmt_pkg::OP_DELETE) begin
                  slot_live[id] = 1'b0;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      bp_result_type got;
      bp_result_type want;
      int            delta;
      if (reset) begin
         load_base = '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_live[i] = 1'b0;
         end
         pending_rsp.delete();
         outstanding <= 0;
      end else begin
         delta = 0;
         if (csr_wr_en) begin
            load_base = csr_wr_data;
         end
         // a response always belongs to an earlier request, so pop before push
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.ok, rsp_mon.slot, rsp_mon.stored_byte, rsp_mon.stored_address};
            if (pending_rsp.size() == 0) begin
               report_mismatch($sformatf("response with none pending (ok %b slot %0d)",
                                         got.ok, got.slot));
            end else begin
               want = pending_rsp.pop_front();
               delta--;
               if (got.ok !== want.ok)
                  report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
               if (got.slot !== want.slot)
                  report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
               if (got.stored_byte !== want.stored_byte)
                  report_mismatch($sformatf("stored_byte %h, want %h",
                                            got.stored_byte, want.stored_byte));
               if (got.stored_address !== want.stored_address)
                  report_mismatch($sformatf("stored_address %h, want %h",
                                            got.stored_address, want.stored_address));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_rsp.push_back(apply_request(bmt_pkg::opcode_type'(req_mon.opcode),
                                                req_mon.address, req_mon.original_byte,
                                                req_mon.slot_id));
            delta++;
         end
         outstanding <= outstanding + delta;
      end
   end

endmodule

FILE: bench/breakpoint_match_table_test.sv
// Testbench top for the breakpoint match table: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module breakpoint_match_table_test;

   localparam int TABLE_ENTRIES  = 16;
   localparam int ITEMS_PER_PASS = 92;   // six random passes, about 550 items
   localparam int PASSES         = 6;
   // slowest transaction is a full hit scan over all 16 slots
   localparam int SETTLE_CYCLES  = 40;
   localparam int QUIET_LIMIT    = 2000;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [bmt_pkg::ADDR_W-1:0] csr_wr_data;

   bmt_req_if req_if ();
   bmt_rsp_if rsp_if ();

   int errors;
   int outstanding;

   // pacing knobs, set by the stimulus process
   bit calm;        // final pass: no idling on either side
   bit idle_on;     // current stretch allows idle bursts
   bit filling;     // current stretch leans toward inserts

   logic [bmt_pkg::ADDR_W-1:0] base_now;       // value last written to base_offset
   logic [bmt_pkg::ADDR_W-1:0] addr_pool[6];   // recurring breakpoint addresses per pass

   int rsp_stall_left;
   int quiet_cycles;

   breakpoint_match_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   bmt_table_checker #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) table_model (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Response side back-pressure: stall bursts of random length while idling is
   // allowed, ready held high in the final pass and during reset.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_if.ready   <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= $urandom_range(1, 18) - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Watchdog: a quiet stretch that reaches QUIET_LIMIT without a transaction on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request and hold it until the table takes it. valid is only
   // dropped ahead of an idle burst or in settle, so back-to-back requests keep it high.
   task automatic send_req(bmt_pkg::opcode_type op, logic [bmt_pkg::ADDR_W-1:0] addr,
                           logic [bmt_pkg::BYTE_W-1:0] orig,
                           logic [bmt_pkg::ID_W-1:0] id);
      int gap;
      if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.opcode        <= op;
      req_if.address       <= addr;
      req_if.original_byte <= orig;
      req_if.slot_id       <= id;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stop sending, wait for every pending response, then idle a while.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(logic [bmt_pkg::ADDR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      base_now     = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One random request. Addresses mostly come from a small pool so that hit
   // checks land on stored entries and duplicates pile up; ids mostly fall
   // inside the table. The op mix drifts between filling and draining so the
   // table passes through both empty and full.
   task automatic random_req();
      int                         pick;
      bmt_pkg::opcode_type        op;
      logic [bmt_pkg::ADDR_W-1:0] addr;
      logic [bmt_pkg::ID_W-1:0]   id;
      pick = $urandom_range(0, 99);
      if (filling) begin
         op = (pick < 45) ? bmt_pkg::OP_INSERT : (pick < 72) ? bmt_pkg::OP_HIT :
              (pick < 86) ? bmt_pkg::OP_DELETE : bmt_pkg::OP_FIND;
      end else begin
         op = (pick < 12) ? bmt_pkg::OP_INSERT : (pick < 42) ? bmt_pkg::OP_HIT :
              (pick < 82) ? bmt_pkg::OP_DELETE : bmt_pkg::OP_FIND;
      end
      if ($urandom_range(0, 9) < 6) begin
         addr = addr_pool[$urandom_range(0, 5)];
      end else begin
         addr = {$urandom, $urandom};
      end
      // probe the rebased address most of the time
      if (op == bmt_pkg::OP_HIT && $urandom_range(0, 9) < 7) begin
         addr = addr + base_now;
      end
      id = ($urandom_range(0, 9) < 8) ?
           bmt_pkg::ID_W'($urandom_range(0, TABLE_ENTRIES - 1)) :
           bmt_pkg::ID_W'($urandom_range(0, 255));
      send_req(op, addr, bmt_pkg::BYTE_W'($urandom_range(0, 255)), id);
   endtask

   initial begin
      reset                = 1'b1;
      calm                 = 1'b0;
      idle_on              = 1'b1;
      filling              = 1'b0;
      base_now             = '0;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_if.valid         = 1'b0;
      req_if.opcode        = bmt_pkg::OP_HIT;
      req_if.address       = '0;
      req_if.original_byte = '0;
      req_if.slot_id       = '0;
      rsp_if.ready         = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, base_offset at its reset value of 0 ---
      send_req(bmt_pkg::OP_HIT,    '0, 8'h00, 8'h00);   // empty table, no match
      send_req(bmt_pkg::OP_DELETE, '1, 8'hFF, 8'h00);   // delete of a free slot
      send_req(bmt_pkg::OP_INSERT, '0, 8'h00, 8'hFF);   // slot 0, all-zero fields
      send_req(bmt_pkg::OP_INSERT, '1, 8'hFF, 8'h00);   // slot 1, all-one fields
      send_req(bmt_pkg::OP_INSERT, '1, 8'hA5, 8'h01);   // duplicate address into slot 2
      send_req(bmt_pkg::OP_HIT,    '1, 8'h00, 8'h00);   // two matches, lowest wins
      send_req(bmt_pkg::OP_FIND,   '0, 8'h00, 8'hFF);   // id far out of range
      send_req(bmt_pkg::OP_DELETE, '0, 8'h00, 8'h01);   // reports contents before clearing
      send_req(bmt_pkg::OP_HIT,    '1, 8'h00, 8'h00);   // now only slot 2 matches
      send_req(bmt_pkg::OP_FIND,   '0, 8'h00, 8'h01);   // freed slot is gone
      send_req(bmt_pkg::OP_INSERT, 64'h1234, 8'h3C, 8'h00); // reuses freed slot 1
      for (int i = 3; i < TABLE_ENTRIES; i++) begin
         send_req(bmt_pkg::OP_INSERT,
                  64'h0000_7FFF_0000_0000 + bmt_pkg::ADDR_W'(i * 16),
                  bmt_pkg::BYTE_W'(i * 17), bmt_pkg::ID_W'(i));
      end
      send_req(bmt_pkg::OP_INSERT, 64'hDEAD_BEEF_0000_0001, 8'h77, 8'h00);  // table full

      // base at its top value: stored address plus base wraps around
      settle();
      write_base('1);
      send_req(bmt_pkg::OP_HIT,  64'hFFFF_FFFF_FFFF_FFFE, 8'h00, 8'h00);  // slot 2 after wrap
      send_req(bmt_pkg::OP_HIT,  '1,                      8'h00, 8'h00);  // slot 0 after wrap
      send_req(bmt_pkg::OP_FIND, '0,                      8'h00, 8'h0F);  // last slot present

      // --- random part, one base_offset setting per pass ---
      for (int pass = 0; pass < PASSES; pass++) begin
         if (pass > 0) begin
            settle();
            case (pass)
               1:       write_base(64'd1);
               2:       write_base(64'h8000_0000_0000_0000);
               5:       write_base('0);
               default: write_base({$urandom, $urandom});
            endcase
         end
         calm = (pass == PASSES - 1);
         addr_pool[0] = bmt_pkg::ADDR_W'($urandom_range(0, 3));
         for (int k = 1; k < 6; k++) begin
            addr_pool[k] = {$urandom, $urandom};
         end
         for (int n = 0; n < ITEMS_PER_PASS; n++) begin
            if (n % 30 == 0) idle_on = ($urandom_range(0, 2) != 0);
            if (n % 40 == 0) filling = !filling;
            random_req();
         end
      end

      settle();
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: breakpoint_match_table.f
design/bmt_pkg.sv
design/bmt_req_if.sv
design/bmt_rsp_if.sv
design/bmt_ram.sv
design/bmt_dp.sv
design/bmt_ctl.sv
design/breakpoint_match_table.sv
bench/bmt_table_checker.sv
bench/breakpoint_match_table_test.sv
